// ===== rtl/core/tmpred_pkg.sv =====
// ----------------------------------------------------------------------------
// tmpred_pkg
// Shared types, codes and arithmetic helpers for the trapezoid motion
// predictor: command and status records, phase codes, saturation functions.
// ----------------------------------------------------------------------------
package tmpred_pkg;

    localparam int TICK_W     = 48;
    localparam int POS_W      = 48;
    localparam int SPD_W      = 32;
    localparam int RDIST_W    = 47;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 47;
    localparam int MCAND_W    = 80;
    localparam int MPL_W      = 48;
    localparam int PROD_W     = 128;
    localparam int DVD_W      = 56;
    localparam int DISP_W     = 64;
    localparam int PH_W       = 3;

    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_PREDICT = 2'd1;
    localparam logic [1:0] FUNC_ABORT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RDIST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RTICKS = 3'd4;

    localparam logic [PH_W-1:0] PH_BEFORE = 3'd0;
    localparam logic [PH_W-1:0] PH_ACCEL  = 3'd1;
    localparam logic [PH_W-1:0] PH_SLEW   = 3'd2;
    localparam logic [PH_W-1:0] PH_DECEL  = 3'd3;
    localparam logic [PH_W-1:0] PH_DONE   = 3'd4;

    localparam logic [DISP_W-1:0] DISP_CAP = 64'h4000_0000_0000_0000;

    localparam logic signed [65:0] POS_MAX66 = {{19{1'b0}}, {47{1'b1}}};
    localparam logic signed [65:0] POS_MIN66 = {{19{1'b1}}, {47{1'b0}}};

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_PLAN,
        OP_TRI_BB,
        OP_SQRT,
        OP_DIV_M,
        OP_TICKS,
        OP_REGION,
        OP_LIN,
        OP_LIN_ACC,
        OP_RR,
        OP_AR2,
        OP_QUAD_ACC,
        OP_AR,
        OP_VEL,
        OP_POS,
        OP_FREEZE,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0]      func;
        logic            trap;
        logic [PH_W-1:0] phase;
        logic            quad_need;
        logic            unit_busy;
    } dp_stat_t;

    // product shifted right by k, capped at 2^62
    function automatic logic [DISP_W-1:0] cap_shr(input logic [PROD_W-1:0] p,
                                                  input int unsigned k);
        logic [PROD_W-1:0] v;
        v = p >> k;
        if (v > {64'd0, DISP_CAP})
            cap_shr = DISP_CAP;
        else
            cap_shr = v[DISP_W-1:0];
    endfunction

    // saturating move of a position by a displacement
    function automatic logic signed [POS_W-1:0] pos_move(input logic signed [POS_W-1:0] p,
                                                         input logic [DISP_W-1:0] d,
                                                         input logic down);
        logic signed [65:0] pe;
        logic signed [65:0] de;
        logic signed [65:0] s;
        pe = {{18{p[POS_W-1]}}, p};
        de = {2'b00, d};
        s  = down ? (pe - de) : (pe + de);
        if (s > POS_MAX66)
            pos_move = POS_MAX66[POS_W-1:0];
        else if (s < POS_MIN66)
            pos_move = POS_MIN66[POS_W-1:0];
        else
            pos_move = s[POS_W-1:0];
    endfunction

    // signed, saturated velocity from magnitude and direction
    function automatic logic [31:0] vel_out(input logic [DISP_W-1:0] v, input logic neg);
        logic [32:0] t;
        t = 33'h1_0000_0000 - {1'b0, v[31:0]};
        if (v == '0)
            vel_out = 32'd0;
        else if (neg)
            vel_out = (v >= 64'h8000_0000) ? 32'h8000_0000 : t[31:0];
        else
            vel_out = (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
    endfunction

endpackage

// ===== rtl/core/tmpred_dp.sv =====
// ----------------------------------------------------------------------------
// tmpred_dp
// Datapath: configuration and plan registers, shift-add multiplier,
// restoring divider, bit-pair square root and the phase/position logic.
// ----------------------------------------------------------------------------
module tmpred_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tmpred_pkg::dp_cmd_t                    cmd,
    output tmpred_pkg::dp_stat_t                   stat,
    input  logic                                   cfg_valid,
    input  logic [tmpred_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tmpred_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [1:0]                             func,
    input  logic [tmpred_pkg::TICK_W-1:0]          now_tick,
    input  logic signed [tmpred_pkg::POS_W-1:0]    from_position,
    input  logic signed [tmpred_pkg::POS_W-1:0]    to_position,
    output logic signed [tmpred_pkg::POS_W-1:0]    position,
    output logic signed [31:0]                     velocity,
    output logic [tmpred_pkg::PH_W-1:0]            phase,
    output logic                                   busy_res,
    output logic [tmpred_pkg::TICK_W-1:0]          finish_tick
);
    import tmpred_pkg::*;

    logic [SPD_W-1:0]   base_reg, slew_reg, accel_reg, rticks_reg;
    logic [RDIST_W-1:0] rdist_reg;

    logic [1:0]              func_reg;
    logic [TICK_W-1:0]       now_reg;
    logic signed [POS_W-1:0] from_reg, to_reg;

    logic [TICK_W-1:0]       t0_reg, t1_reg, t2_reg, t3_reg;
    logic signed [POS_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg;

    logic [PH_W-1:0]         ph_reg;
    logic [TICK_W-1:0]       r_reg;
    logic                    neg_reg;
    logic [DISP_W-1:0]       disp_reg, vmag_reg, psat_reg;
    logic signed [POS_W-1:0] pos_reg;

    logic [PROD_W-1:0] mcand_reg, prod_reg;
    logic [MPL_W-1:0]  mpl_reg;
    logic              mul_busy_reg;

    logic [DVD_W-1:0] dvd_reg;
    logic [SPD_W-1:0] dvs_reg, rem_reg;
    logic [5:0]       dcnt_reg;
    logic             div_busy_reg;

    logic [63:0] sq_rem_reg, root_reg, sbit_reg;
    logic        sq_busy_reg;

    logic signed [POS_W-1:0] position_reg;
    logic [31:0]             velocity_reg;
    logic [PH_W-1:0]         phase_reg;
    logic                    busy_res_reg;
    logic [TICK_W-1:0]       finish_reg;

    // plan arithmetic
    logic signed [POS_W:0]   delta, sum_ft, hdiff;
    logic                    move_neg, trap;
    logic [POS_W:0]          absd_w, h_w;
    logic [TICK_W-1:0]       absd, d2, h;
    logic [DVD_W-1:0]        slew_num, m_num;
    logic signed [POS_W-1:0] rd, acc_pos, dec_pos, mid;
    logic [63:0]             p2x, v2;
    logic [64:0]             v2sum;
    logic                    ms_gt;
    logic [57:0]             r1w, r2w, r3w;
    logic [TICK_W-1:0]       t1_next, t2_next, t3_next;

    // region and predict arithmetic
    logic [PH_W-1:0]   ph_next;
    logic [TICK_W-1:0] r_next;
    logic [DISP_W-1:0] quad_pre;

    // unit launches
    logic               mul_go, div_go, sq_go;
    logic [MCAND_W-1:0] mul_a;
    logic [MPL_W-1:0]   mul_b;
    logic [DVD_W-1:0]   div_num;
    logic [SPD_W-1:0]   div_den;

    logic [32:0] dtrial, ddiff;
    logic        dge;
    logic [64:0] strial;
    logic        sge;

    function automatic logic [TICK_W-1:0] sat_tick(input logic [57:0] x);
        sat_tick = (x[57:TICK_W] != '0) ? {TICK_W{1'b1}} : x[TICK_W-1:0];
    endfunction

    always_comb
    begin
        delta    = $signed({to_reg[POS_W-1], to_reg}) - $signed({from_reg[POS_W-1], from_reg});
        move_neg = delta[POS_W];
        absd_w   = move_neg ? -delta : delta;
        absd     = absd_w[TICK_W-1:0];
        d2       = {rdist_reg, 1'b0};
        trap     = (absd >= d2);
        slew_num = {absd - d2, 8'd0};
        rd       = {1'b0, rdist_reg};
        acc_pos  = move_neg ? (from_reg - rd) : (from_reg + rd);
        dec_pos  = move_neg ? (to_reg + rd) : (to_reg - rd);
        sum_ft   = $signed({from_reg[POS_W-1], from_reg}) + $signed({to_reg[POS_W-1], to_reg});
        mid      = sum_ft[POS_W:1];
        hdiff    = $signed({mid[POS_W-1], mid}) - $signed({from_reg[POS_W-1], from_reg});
        h_w      = hdiff[POS_W] ? -hdiff : hdiff;
        h        = h_w[TICK_W-1:0];

        p2x   = psat_reg[63] ? {64{1'b1}} : {psat_reg[62:0], 1'b0};
        v2sum = {1'b0, prod_reg[63:0]} + {1'b0, p2x};
        v2    = v2sum[64] ? {64{1'b1}} : v2sum[63:0];
        ms_gt = (root_reg > {32'd0, base_reg});
        m_num = {16'd0, root_reg[31:0] - base_reg, 8'd0};

        r1w = trap ? {26'd0, rticks_reg} : {2'd0, dvd_reg};
        r2w = trap ? ({26'd0, rticks_reg} + {2'd0, dvd_reg}) : {2'd0, dvd_reg};
        r3w = trap ? ({25'd0, rticks_reg, 1'b0} + {2'd0, dvd_reg}) : {1'b0, dvd_reg, 1'b0};
        t1_next = now_reg + sat_tick(r1w);
        t2_next = now_reg + sat_tick(r2w);
        t3_next = now_reg + sat_tick(r3w);

        if (now_reg >= t3_reg)
        begin
            ph_next = PH_DONE;
            r_next  = '0;
        end
        else if (now_reg >= t2_reg)
        begin
            ph_next = PH_DECEL;
            r_next  = t3_reg - now_reg;
        end
        else if (now_reg >= t1_reg)
        begin
            ph_next = PH_SLEW;
            r_next  = now_reg - t1_reg;
        end
        else if (now_reg >= t0_reg)
        begin
            ph_next = PH_ACCEL;
            r_next  = now_reg - t0_reg;
        end
        else
        begin
            ph_next = PH_BEFORE;
            r_next  = '0;
        end

        if (ph_reg == PH_SLEW || accel_reg == '0)
            quad_pre = '0;
        else if (r_reg[TICK_W-1:40] != '0)
            quad_pre = DISP_CAP;
        else
            quad_pre = '0;
    end

    always_comb
    begin
        mul_go  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        div_go  = 1'b0;
        div_num = '0;
        div_den = '0;
        sq_go   = 1'b0;
        case (cmd.op)
            OP_PLAN:
            begin
                if (trap)
                begin
                    div_go  = 1'b1;
                    div_num = slew_num;
                    div_den = slew_reg;
                end
                else
                begin
                    mul_go = 1'b1;
                    mul_a  = {32'd0, h};
                    mul_b  = {16'd0, accel_reg};
                end
            end
            OP_TRI_BB:
            begin
                mul_go = 1'b1;
                mul_a  = {48'd0, base_reg};
                mul_b  = {16'd0, base_reg};
            end
            OP_SQRT:
                sq_go = 1'b1;
            OP_DIV_M:
            begin
                div_go  = 1'b1;
                div_num = m_num;
                div_den = ms_gt ? accel_reg : '0;
            end
            OP_LIN:
            begin
                mul_go = 1'b1;
                mul_a  = {32'd0, r_reg};
                mul_b  = {16'd0, (ph_reg == PH_SLEW) ? slew_reg : base_reg};
            end
            OP_RR:
            begin
                mul_go = 1'b1;
                mul_a  = {32'd0, r_reg};
                mul_b  = r_reg;
            end
            OP_AR2:
            begin
                mul_go = 1'b1;
                mul_a  = prod_reg[MCAND_W-1:0];
                mul_b  = {16'd0, accel_reg};
            end
            OP_AR:
            begin
                mul_go = 1'b1;
                mul_a  = {32'd0, r_reg};
                mul_b  = {16'd0, accel_reg};
            end
            default:
            begin
            end
        endcase
    end

    // shift-add multiplier, one multiplier bit a cycle, stops early
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_busy_reg <= 1'b0;
        else if (mul_go)
            mul_busy_reg <= (mul_b != '0);
        else if (mul_busy_reg)
            mul_busy_reg <= (mpl_reg[MPL_W-1:1] != '0);
    end

    always_ff @(posedge clk)
    begin
        if (mul_go)
        begin
            mcand_reg <= {48'd0, mul_a};
            mpl_reg   <= mul_b;
            prod_reg  <= '0;
        end
        else if (mul_busy_reg)
        begin
            if (mpl_reg[0])
                prod_reg <= prod_reg + mcand_reg;
            mcand_reg <= {mcand_reg[PROD_W-2:0], 1'b0};
            mpl_reg   <= {1'b0, mpl_reg[MPL_W-1:1]};
        end
    end

    // restoring divider; a zero divisor gives a zero quotient
    assign dtrial = {rem_reg, dvd_reg[DVD_W-1]};
    assign ddiff  = dtrial - {1'b0, dvs_reg};
    assign dge    = (dtrial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            dcnt_reg     <= '0;
        end
        else if (div_go)
        begin
            div_busy_reg <= (div_den != '0);
            dcnt_reg     <= 6'(DVD_W);
        end
        else if (div_busy_reg)
        begin
            div_busy_reg <= (dcnt_reg != 6'd1);
            dcnt_reg     <= dcnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_go)
        begin
            dvd_reg <= (div_den == '0) ? '0 : div_num;
            dvs_reg <= div_den;
            rem_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            rem_reg <= dge ? ddiff[SPD_W-1:0] : dtrial[SPD_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], dge};
        end
    end

    // square root, two radicand bits a cycle
    assign strial = {1'b0, root_reg} + {1'b0, sbit_reg};
    assign sge    = ({1'b0, sq_rem_reg} >= strial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_busy_reg <= 1'b0;
        else if (sq_go)
            sq_busy_reg <= 1'b1;
        else if (sq_busy_reg)
            sq_busy_reg <= (sbit_reg[63:2] != '0);
    end

    always_ff @(posedge clk)
    begin
        if (sq_go)
        begin
            sq_rem_reg <= v2;
            root_reg   <= '0;
            sbit_reg   <= 64'h4000_0000_0000_0000;
        end
        else if (sq_busy_reg)
        begin
            if (sge)
            begin
                sq_rem_reg <= sq_rem_reg - strial[63:0];
                root_reg   <= {1'b0, root_reg[63:1]} + sbit_reg;
            end
            else
                root_reg <= {1'b0, root_reg[63:1]};
            sbit_reg <= {2'b00, sbit_reg[63:2]};
        end
    end

    // configuration and plan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            slew_reg   <= '0;
            accel_reg  <= '0;
            rdist_reg  <= '0;
            rticks_reg <= '0;
            t0_reg     <= '0;
            t1_reg     <= '0;
            t2_reg     <= '0;
            t3_reg     <= '0;
            p0_reg     <= '0;
            p1_reg     <= '0;
            p2_reg     <= '0;
            p3_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_BASE:   base_reg   <= cfg_data[SPD_W-1:0];
                    CFG_SLEW:   slew_reg   <= cfg_data[SPD_W-1:0];
                    CFG_ACCEL:  accel_reg  <= cfg_data[SPD_W-1:0];
                    CFG_RDIST:  rdist_reg  <= cfg_data[RDIST_W-1:0];
                    CFG_RTICKS: rticks_reg <= cfg_data[SPD_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            case (cmd.op)
                OP_PLAN:
                begin
                    p0_reg <= from_reg;
                    p3_reg <= to_reg;
                    p1_reg <= trap ? acc_pos : mid;
                    p2_reg <= trap ? dec_pos : mid;
                end
                OP_TICKS:
                begin
                    t0_reg <= now_reg;
                    t1_reg <= t1_next;
                    t2_reg <= t2_next;
                    t3_reg <= t3_next;
                end
                OP_FREEZE:
                begin
                    t0_reg <= now_reg;
                    t1_reg <= now_reg;
                    t2_reg <= now_reg;
                    t3_reg <= now_reg;
                    p0_reg <= pos_reg;
                    p1_reg <= pos_reg;
                    p2_reg <= pos_reg;
                    p3_reg <= pos_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                func_reg <= func;
                now_reg  <= now_tick;
                from_reg <= from_position;
                to_reg   <= to_position;
            end
            OP_TRI_BB:
                psat_reg <= (prod_reg[PROD_W-1:64] != '0) ? {64{1'b1}} : prod_reg[63:0];
            OP_REGION:
            begin
                ph_reg  <= ph_next;
                r_reg   <= r_next;
                neg_reg <= (p3_reg < p0_reg);
            end
            OP_LIN_ACC:
                disp_reg <= cap_shr(prod_reg, 8) + quad_pre;
            OP_QUAD_ACC:
                disp_reg <= disp_reg + cap_shr(prod_reg, 17);
            OP_VEL:
                vmag_reg <= {32'd0, base_reg} + cap_shr(prod_reg, 8);
            OP_POS:
            begin
                case (ph_reg)
                    PH_BEFORE:
                    begin
                        pos_reg  <= p0_reg;
                        vmag_reg <= '0;
                    end
                    PH_ACCEL:
                        pos_reg <= pos_move(p0_reg, disp_reg, neg_reg);
                    PH_SLEW:
                    begin
                        pos_reg  <= pos_move(p1_reg, disp_reg, neg_reg);
                        vmag_reg <= {32'd0, slew_reg};
                    end
                    PH_DECEL:
                        pos_reg <= pos_move(p3_reg, disp_reg, !neg_reg);
                    default:
                    begin
                        pos_reg  <= p3_reg;
                        vmag_reg <= '0;
                    end
                endcase
            end
            OP_OUT:
            begin
                position_reg <= pos_reg;
                velocity_reg <= vel_out(vmag_reg, neg_reg);
                phase_reg    <= ph_reg;
                busy_res_reg <= (ph_reg != PH_DONE);
                finish_reg   <= t3_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.func      = func_reg;
    assign stat.trap      = trap;
    assign stat.phase     = ph_reg;
    assign stat.quad_need = (accel_reg != '0) && (r_reg[TICK_W-1:40] == '0);
    assign stat.unit_busy = mul_busy_reg | div_busy_reg | sq_busy_reg;

    assign position    = position_reg;
    assign velocity    = $signed(velocity_reg);
    assign phase       = phase_reg;
    assign busy_res    = busy_res_reg;
    assign finish_tick = finish_reg;

endmodule

// ===== rtl/core/tmpred_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmpred_ctrl
// Sequencer: takes one command, steps the datapath through planning and
// prediction, and holds the result valid until it is transferred.
// ----------------------------------------------------------------------------
module tmpred_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  tmpred_pkg::dp_stat_t  stat,
    output tmpred_pkg::dp_cmd_t   cmd
);
    import tmpred_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_PLAN_WAIT,
        S_BB_WAIT,
        S_SQ_WAIT,
        S_DIV_WAIT,
        S_TICKS,
        S_REGION,
        S_PHASE,
        S_LIN_WAIT,
        S_QUAD,
        S_RR_WAIT,
        S_AR2_WAIT,
        S_VEL,
        S_AR_WAIT,
        S_POS,
        S_FREEZE,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   frozen_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.func == FUNC_START)
                begin
                    cmd.op     = OP_PLAN;
                    state_next = S_PLAN_WAIT;
                end
                else
                    state_next = S_REGION;
            end
            S_PLAN_WAIT:
            begin
                if (!stat.unit_busy)
                begin
                    if (stat.trap)
                        state_next = S_TICKS;
                    else
                    begin
                        cmd.op     = OP_TRI_BB;
                        state_next = S_BB_WAIT;
                    end
                end
            end
            S_BB_WAIT:
            begin
                if (!stat.unit_busy)
                begin
                    cmd.op     = OP_SQRT;
                    state_next = S_SQ_WAIT;
                end
            end
            S_SQ_WAIT:
            begin
                if (!stat.unit_busy)
                begin
                    cmd.op     = OP_DIV_M;
                    state_next = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT:
            begin
                if (!stat.unit_busy)
                    state_next = S_TICKS;
            end
            S_TICKS:
            begin
                cmd.op     = OP_TICKS;
                state_next = S_REGION;
            end
            S_REGION:
            begin
                cmd.op     = OP_REGION;
                state_next = S_PHASE;
            end
            S_PHASE:
            begin
                if (stat.phase == PH_ACCEL || stat.phase == PH_SLEW
                    || stat.phase == PH_DECEL)
                begin
                    cmd.op     = OP_LIN;
                    state_next = S_LIN_WAIT;
                end
                else
                    state_next = S_POS;
            end
            S_LIN_WAIT:
            begin
                if (!stat.unit_busy)
                begin
                    cmd.op     = OP_LIN_ACC;
                    state_next = S_QUAD;
                end
            end
            S_QUAD:
            begin
                if (stat.phase == PH_SLEW)
                    state_next = S_POS;
                else if (stat.quad_need)
                begin
                    cmd.op     = OP_RR;
                    state_next = S_RR_WAIT;
                end
                else
                    state_next = S_VEL;
            end
            S_RR_WAIT:
            begin
                if (!stat.unit_busy)
                begin
                    cmd.op     = OP_AR2;
                    state_next = S_AR2_WAIT;
                end
            end
            S_AR2_WAIT:
            begin
                if (!stat.unit_busy)
                begin
                    cmd.op     = OP_QUAD_ACC;
                    state_next = S_VEL;
                end
            end
            S_VEL:
            begin
                cmd.op     = OP_AR;
                state_next = S_AR_WAIT;
            end
            S_AR_WAIT:
            begin
                if (!stat.unit_busy)
                begin
                    cmd.op     = OP_VEL;
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                cmd.op = OP_POS;
                if (stat.func == FUNC_ABORT && !frozen_reg)
                    state_next = S_FREEZE;
                else
                    state_next = S_OUT;
            end
            S_FREEZE:
            begin
                // park the plan at the predicted point, then predict again
                cmd.op     = OP_FREEZE;
                state_next = S_REGION;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            frozen_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE)
                frozen_reg <= 1'b0;
            else if (state_reg == S_FREEZE)
                frozen_reg <= 1'b1;
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/trapezoid_motion_predictor_core.sv =====
// ----------------------------------------------------------------------------
// trapezoid_motion_predictor_core
// Dead-reckoning predictor for a constant-acceleration move: plans a
// trapezoid or triangle profile and reports position, velocity and phase.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid / in_ready  | func, now_tick, from_position, to_position
//  out      | out_valid/out_ready  | position, velocity, phase, busy_res,
//           |                      | finish_tick
//  cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  One command at a time. Inside a move a predict runs the multiplier;
//  an abort predicts, parks the plan at the predicted point and predicts
//  again. A start first plans: a trapezoid needs one division, a triangle
//  two multiplies, a square root and a division. The work runs on the
//  shift-add multiplier (one multiplier bit a cycle), the 56-bit divider
//  and the bit-pair square root. A finished result sits in the output
//  register while the next command is taken; a stalled output holds the
//  sequencer before its final write. Reset clears configuration and plan.
// ----------------------------------------------------------------------------
module trapezoid_motion_predictor_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           func,
    input  logic [tmpred_pkg::TICK_W-1:0]        now_tick,
    input  logic signed [tmpred_pkg::POS_W-1:0]  from_position,
    input  logic signed [tmpred_pkg::POS_W-1:0]  to_position,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tmpred_pkg::POS_W-1:0]  position,
    output logic signed [31:0]                   velocity,
    output logic [tmpred_pkg::PH_W-1:0]          phase,
    output logic                                 busy_res,
    output logic [tmpred_pkg::TICK_W-1:0]        finish_tick,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tmpred_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmpred_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tmpred_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    tmpred_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tmpred_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (func),
        .now_tick      (now_tick),
        .from_position (from_position),
        .to_position   (to_position),
        .position      (position),
        .velocity      (velocity),
        .phase         (phase),
        .busy_res      (busy_res),
        .finish_tick   (finish_tick)
    );

endmodule

// ===== rtl/core/tmpred_checker.sv =====
// ----------------------------------------------------------------------------
// tmpred_checker
// Port-level checks for the trapezoid motion predictor, bound to the core.
// ----------------------------------------------------------------------------
module tmpred_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [tmpred_pkg::POS_W-1:0]  position,
    input logic signed [31:0]                   velocity,
    input logic [tmpred_pkg::PH_W-1:0]          phase,
    input logic                                 busy_res
);
    import tmpred_pkg::*;

    // busy flag agrees with the reported phase
    a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (busy_res == (phase != PH_DONE)))
        else $error("busy_res disagrees with phase");

    // no motion outside a move
    a_still: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase == PH_DONE || phase == PH_BEFORE) |-> (velocity == 32'sd0))
        else $error("nonzero velocity outside a move");

    // one command in flight: a transfer closes the input for the next cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a command is in progress");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position) && $stable(phase))
        else $error("stalled result changed");

endmodule

bind trapezoid_motion_predictor_core tmpred_checker u_tmpred_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .position  (position),
    .velocity  (velocity),
    .phase     (phase),
    .busy_res  (busy_res)
);
